// ===== rtl/core/rcdg_pkg.sv =====
// Shared constants, types and helpers for the RGB central-difference gradient unit.
// No dependencies; used by the top level by scoped names.
package rcdg_pkg;

  // Line store sizing
  localparam int MaxWidth  = 1024;
  localparam int WidthCap  = (MaxWidth < 1024) ? MaxWidth : 1024;
  localparam int HeightCap = 1024;
  localparam int ColW      = $clog2(WidthCap);

  // Field widths
  localparam int DimW    = 11;
  localparam int ChanW   = 8;
  localparam int PixW    = 3 * ChanW;
  localparam int DiffW   = ChanW + 1;
  localparam int GradW   = ChanW + 2;
  localparam int OutPosW = 10;
  localparam int InDataW  = PixW;
  localparam int OutDataW = 56;
  localparam int CfgIdxW  = 2;

  localparam logic [DimW-1:0] DimMin       = DimW'(3);
  localparam logic [DimW-1:0] WidthCapV    = DimW'(WidthCap);
  localparam logic [DimW-1:0] HeightCapV   = DimW'(HeightCap);
  localparam logic [DimW-1:0] WidthReset   = (WidthCap < 640) ? DimW'(WidthCap) : DimW'(640);
  localparam logic [DimW-1:0] HeightReset  = DimW'(480);

  typedef enum logic [CfgIdxW-1:0] {
    CfgFrameWidth  = 2'd0,
    CfgFrameHeight = 2'd1
  } cfg_reg_e;

  typedef enum logic {
    OpPixel   = 1'b0,
    OpPadding = 1'b1
  } item_op_e;

  // Control carried from the read stage to the compute stage
  typedef struct packed {
    logic                  final_item;
    logic                  emit_mid;
    logic                  emit_wrap;
    logic                  hd_en;
    logic                  vd_en;
    logic [ColW-1:0]       col;
    logic [OutPosW-1:0]    ocol;
    logic [OutPosW-1:0]    orow;
    logic [PixW-1:0]       px;
  } s1_ctrl_t;

  function automatic logic [DimW-1:0] clamp_dim(input logic [DimW-1:0] v,
                                                input logic [DimW-1:0] cap);
    logic [DimW-1:0] r;
    begin
      if (v < DimMin) r = DimMin;
      else if (v > cap) r = cap;
      else r = v;
      return r;
    end
  endfunction

endpackage

// ===== rtl/core/rcdg_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module rcdg_ram #(
  parameter int Width = 8,
  parameter int Depth = 16,
  parameter int AddrW = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/core/rgb_central_difference_gradient_unit.sv =====
// RGB central-difference gradient unit: line stores in one RAM, window and output register.
// Depends on rcdg_pkg and rcdg_ram.
// Throughput: one beat per clock unless the output stalls; the line store is read per taken beat
//   and written back for all but the closing one. Result (r,c) comes from the beat of (r+1,c+1),
//   then registered; frame_width+1 padding beats after the last pixel drain the frame.
// Reset: sizes 640x480, position and window cleared; line store left unset (written before use).
module rgb_central_difference_gradient_unit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // pixel stream in
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [rcdg_pkg::InDataW-1:0]  s_axis_tdata,  // red[7:0], green[15:8], blue[23:16]
  input  logic                          s_axis_tuser,  // op: 0 pixel, 1 padding
  // gradient stream out
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [rcdg_pkg::OutDataW-1:0] m_axis_tdata,  // grad_red[9:0], grad_green[19:10],
                                                       // grad_blue[29:20], out_col[39:30],
                                                       // out_row[49:40], zeros[55:50]
  output logic                          m_axis_tlast,  // frame_done
  // register writes
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [rcdg_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [rcdg_pkg::DimW-1:0]     cfg_data_i
);

  localparam int ColW  = rcdg_pkg::ColW;
  localparam int DimW  = rcdg_pkg::DimW;
  localparam int PixW  = rcdg_pkg::PixW;
  localparam int ChanW = rcdg_pkg::ChanW;
  localparam int DiffW = rcdg_pkg::DiffW;
  localparam int GradW = rcdg_pkg::GradW;
  localparam int PosW  = rcdg_pkg::OutPosW;

  // ---------------------------------------------------------------------------
  // Configuration registers. Any known write restarts the frame.
  // ---------------------------------------------------------------------------
  logic [DimW-1:0] width_q, width_d;
  logic [DimW-1:0] height_q, height_d;
  logic            cfg_restart;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    width_d     = width_q;
    height_d    = height_q;
    cfg_restart = 1'b0;
    if (cfg_valid_i) begin
      unique case (rcdg_pkg::cfg_reg_e'(cfg_index_i))
        rcdg_pkg::CfgFrameWidth: begin
          width_d     = rcdg_pkg::clamp_dim(cfg_data_i, rcdg_pkg::WidthCapV);
          cfg_restart = 1'b1;
        end
        rcdg_pkg::CfgFrameHeight: begin
          height_d    = rcdg_pkg::clamp_dim(cfg_data_i, rcdg_pkg::HeightCapV);
          cfg_restart = 1'b1;
        end
        default: ;  // unknown index, dropped
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 0: position tracking, classification and line-store read at col_q.
  // ---------------------------------------------------------------------------
  logic [ColW-1:0] col_q, col_d;
  logic [DimW-1:0] row_q, row_d;

  logic            in_frame, ignore_item, final0, acc, take;
  logic [DimW-1:0] col_inc;
  logic            row_ge1, row_ge2;
  rcdg_pkg::s1_ctrl_t s0_ctrl;

  assign in_frame    = row_q < height_q;
  assign ignore_item = in_frame && (rcdg_pkg::item_op_e'(s_axis_tuser) == rcdg_pkg::OpPadding);
  assign final0      = row_q > height_q;  // closing padding beat of the drain
  assign acc         = s_axis_tvalid && s_axis_tready;
  assign take        = acc && !ignore_item;
  assign col_inc     = DimW'(col_q) + DimW'(1);
  assign row_ge1     = row_q != '0;
  assign row_ge2     = row_q >= DimW'(2);

  always_comb begin
    s0_ctrl            = '0;
    s0_ctrl.final_item = final0;
    s0_ctrl.emit_mid   = (col_q != '0) && row_ge1 && !final0;
    s0_ctrl.emit_wrap  = (col_q == '0) && row_ge2 && !final0;
    s0_ctrl.hd_en      = s0_ctrl.emit_mid && (DimW'(col_q) >= DimW'(2));
    s0_ctrl.vd_en      = row_ge2 && in_frame;
    s0_ctrl.col        = col_q;
    s0_ctrl.px         = in_frame ? s_axis_tdata : '0;
    if (s0_ctrl.emit_mid) begin
      s0_ctrl.ocol = PosW'(DimW'(col_q) - DimW'(1));
      s0_ctrl.orow = PosW'(row_q - DimW'(1));
    end else if (s0_ctrl.emit_wrap) begin
      s0_ctrl.ocol = PosW'(width_q - DimW'(1));
      s0_ctrl.orow = PosW'(row_q - DimW'(2));
    end else begin
      s0_ctrl.ocol = PosW'(width_q - DimW'(1));
      s0_ctrl.orow = PosW'(height_q - DimW'(1));
    end
  end

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (cfg_restart) begin
      col_d = '0;
      row_d = '0;
    end else if (take) begin
      if (final0) begin
        col_d = '0;
        row_d = '0;
      end else if (col_inc >= width_q) begin
        col_d = '0;
        row_d = row_q + DimW'(1);
      end else begin
        col_d = ColW'(col_inc);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Line store: word = {upper row, middle row}, read in stage 0, written back in stage 1.
  // Consecutive beats hit consecutive columns, so read and write never collide.
  // ---------------------------------------------------------------------------
  logic              ram_we, ram_re;
  logic [ColW-1:0]   ram_waddr, ram_raddr;
  logic [2*PixW-1:0] ram_wdata, ram_rdata;

  rcdg_ram #(
    .Width (2 * PixW),
    .Depth (rcdg_pkg::WidthCap)
  ) u_line_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign ram_re    = take;
  assign ram_raddr = col_q;

  // ---------------------------------------------------------------------------
  // Stage 1: differences, window update, write-back.
  // ---------------------------------------------------------------------------
  logic               s1_valid_q, s1_valid_d;
  rcdg_pkg::s1_ctrl_t s1_q;
  logic               s1_emit, s1_go, out_free;

  logic [PixW-1:0] mid_px, up_px;
  logic [PixW-1:0] p1_q, p1_d, p2_q, p2_d;
  logic signed [DiffW-1:0] vd_q [3];
  logic signed [DiffW-1:0] vd_d [3];
  logic signed [DiffW-1:0] hd   [3];
  logic signed [GradW-1:0] grad [3];

  assign mid_px = ram_rdata[PixW-1:0];
  assign up_px  = ram_rdata[2*PixW-1:PixW];

  assign s1_emit  = s1_q.final_item || s1_q.emit_mid || s1_q.emit_wrap;
  assign out_free = !m_axis_tvalid || m_axis_tready;
  assign s1_go    = s1_valid_q && (!s1_emit || out_free);
  assign s_axis_tready = !s1_valid_q || s1_go;

  assign ram_we    = s1_go && !s1_q.final_item;
  assign ram_waddr = s1_q.col;
  assign ram_wdata = {mid_px, s1_q.px};

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      if (s1_q.vd_en) begin
        vd_d[k] = $signed({1'b0, s1_q.px[k*ChanW +: ChanW]})
                - $signed({1'b0, up_px[k*ChanW +: ChanW]});
      end else begin
        vd_d[k] = '0;
      end
      if (s1_q.hd_en) begin
        hd[k] = $signed({1'b0, mid_px[k*ChanW +: ChanW]})
              - $signed({1'b0, p2_q[k*ChanW +: ChanW]});
      end else begin
        hd[k] = '0;
      end
      grad[k] = GradW'(hd[k]) + GradW'(vd_q[k]);
    end
    p1_d = mid_px;
    p2_d = p1_q;
  end

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (cfg_restart) begin
      s1_valid_d = 1'b0;
    end else if (take) begin
      s1_valid_d = 1'b1;
    end else if (s1_go) begin
      s1_valid_d = 1'b0;
    end
  end

  // ---------------------------------------------------------------------------
  // Output register
  // ---------------------------------------------------------------------------
  logic                 out_valid_q, out_valid_d;
  logic                 out_last_q;
  logic [3*GradW-1:0]   out_grad_q;
  logic [PosW-1:0]      out_col_q, out_row_q;
  logic                 out_load;

  assign out_load = s1_go && s1_emit;

  always_comb begin
    out_valid_d = m_axis_tvalid;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tlast  = out_last_q;
  assign m_axis_tdata  = {{(rcdg_pkg::OutDataW - 3*GradW - 2*PosW){1'b0}},
                          out_row_q, out_col_q, out_grad_q};

  // ---------------------------------------------------------------------------
  // Registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q     <= rcdg_pkg::WidthReset;
      height_q    <= rcdg_pkg::HeightReset;
      col_q       <= '0;
      row_q       <= '0;
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      width_q     <= width_d;
      height_q    <= height_d;
      col_q       <= col_d;
      row_q       <= row_d;
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Window: centre-row pixels of the two previous columns, vertical difference of the last
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p1_q <= '0;
      p2_q <= '0;
      for (int k = 0; k < 3; k++) vd_q[k] <= '0;
    end else if (cfg_restart || (s1_go && s1_q.final_item)) begin
      p1_q <= '0;
      p2_q <= '0;
      for (int k = 0; k < 3; k++) vd_q[k] <= '0;
    end else if (s1_go) begin
      p1_q <= p1_d;
      p2_q <= p2_d;
      for (int k = 0; k < 3; k++) vd_q[k] <= vd_d[k];
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      s1_q <= s0_ctrl;
    end
    if (out_load) begin
      out_grad_q <= {grad[2], grad[1], grad[0]};
      out_col_q  <= s1_q.ocol;
      out_row_q  <= s1_q.orow;
      out_last_q <= s1_q.final_item;
    end
  end

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_ram_no_collide: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we && ram_re |-> ram_waddr != ram_raddr)
    else $error("line store read and write hit the same column");

  a_col_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    DimW'(col_q) < width_q)
    else $error("input column beyond frame width");

  a_row_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    row_q <= height_q + DimW'(1))
    else $error("input row beyond drain row");

  a_emit_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q |-> $onehot0({s1_q.final_item, s1_q.emit_mid, s1_q.emit_wrap}))
    else $error("more than one result kind in compute stage");

  a_rdata_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && !s1_go |=> $stable(ram_rdata))
    else $error("line store data lost while compute stage stalled");

endmodule
